// ----- sv/ast_pkg.sv -----
// Package for the action statistics table: sizes, codes and state encoding.
package ast_pkg;

  localparam int CELLS_DEF            = 64;
  localparam int MODIFIERS_DEF        = 8;
  localparam int AUTOMATON_STATES_DEF = 56;
  localparam int MAX_MOVE_ACTIONS_DEF = 64;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

  localparam logic signed [31:0] BASE_SCORE_RST = 32'sd6553600;
  localparam logic [15:0]        FADE_MULT_RST  = 16'd64880;

  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_MOVE   = 2'd1,
    KIND_SINGLE = 2'd2,
    KIND_DECAY  = 2'd3
  } kind_t;

  localparam logic REG_BASE_SCORE = 1'b0;
  localparam logic REG_FADE_MULT  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_ACC,
    ST_DEC_RD,
    ST_DEC_WAIT,
    ST_DEC_MUL,
    ST_DEC_WR,
    ST_OUT
  } state_t;

endpackage

// ----- sv/action_stats_table_decay.sv -----
// Top level of the action statistics table with decay and move averaging.
//
// channel  direction  handshake           payload
// in       input      in_valid/in_ready   kind cell_req action_slot score_value last
// out      output     out_valid/out_ready result_sum result_weight used_default
// cfg      input      cfg_we              cfg_index cfg_data
//
// Beat to next beat: an update reads its entry and writes it back; a single query
// reads it and adds the output state and any stall; an averaged move element also
// runs through the restoring divider, one quotient bit a cycle, and is accumulated;
// the last move element adds the output state and any stall. Decay walks every
// entry: it reads it, multiplies sum then weight in the one shared multiplier,
// writes it back. After reset a clearing pass writes zero to all DEPTH entries,
// one a cycle, with in_ready low; configuration writes are taken throughout.
// A result waits in the output register; the next item is taken only after it.
module action_stats_table_decay
  import ast_pkg::*;
#(
  parameter int CELLS            = CELLS_DEF,
  parameter int MODIFIERS        = MODIFIERS_DEF,
  parameter int AUTOMATON_STATES = AUTOMATON_STATES_DEF,
  parameter int MAX_MOVE_ACTIONS = MAX_MOVE_ACTIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [6:0]         cell_req,
  input  logic [3:0]         action_slot,
  input  logic signed [31:0] score_value,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] result_sum,
  output logic [31:0]        result_weight,
  output logic               used_default,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int STRIDE = MODIFIERS + AUTOMATON_STATES;
  localparam int DEPTH  = CELLS * STRIDE;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(MAX_MOVE_ACTIONS + 1);
  localparam int IW     = AW + 1;

  // configuration registers
  logic signed [31:0] base_score;
  logic [15:0]        fade_mult;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_score <= BASE_SCORE_RST;
      fade_mult  <= FADE_MULT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_BASE_SCORE) base_score <= cfg_data;
      else fade_mult <= cfg_data[15:0];
    end
  end

  // table memory, one sum and weight word per entry
  logic [79:0] mem [DEPTH];
  logic [79:0] rd_data;
  logic [79:0] wr_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  // latched item
  kind_t              k_q;
  logic signed [31:0] score_q;
  logic               last_q;
  logic               valid_q;
  logic [AW-1:0]      idx_q;

  // move state
  logic signed [47:0] move_acc;
  logic [CW-1:0]      move_cnt;
  logic               move_hit;

  // divider operands and decay product
  logic [63:0]        div_rem;
  logic [63:0]        div_num;
  logic [63:0]        div_quo;
  logic [31:0]        div_den;
  logic [6:0]         div_step;
  logic               div_neg;
  logic [79:0]        entry_q;
  logic [63:0]        prod;
  logic               mul_phase;

  logic [AW-1:0]      ptr;
  state_t             state, state_next;

  // index compute
  logic [IW+12:0] idx_full;
  logic           act_ok;
  always_comb begin
    act_ok = (cell_req >= 7'd1) && (32'(cell_req) <= CELLS) &&
             (action_slot >= 4'd1) && (32'(action_slot) <= MODIFIERS);
    idx_full = (IW+13)'((32'(cell_req) - 32'd1) * STRIDE + AUTOMATON_STATES +
                        32'(action_slot) - 32'd1);
  end

  logic signed [47:0] ent_sum;
  logic [31:0]        ent_wt;
  assign ent_sum = entry_q[79:32];
  assign ent_wt  = entry_q[31:0];

  // entry as read from the table, valid in ST_EXEC
  logic signed [47:0] rd_sum;
  logic [31:0]        rd_wt;
  assign rd_sum = rd_data[79:32];
  assign rd_wt  = rd_data[31:0];

  // saturating helpers
  logic signed [48:0] upd_sum, acc_sum;
  logic signed [47:0] upd_sat, acc_sat, q_signed;
  logic [32:0]        wt_sum;
  logic [63:0]        rem_shift;
  logic [64:0]        rem_try;
  always_comb begin
    upd_sum = 49'(rd_sum) + 49'(score_q);
    upd_sat = (upd_sum > 49'(S48_MAX)) ? S48_MAX :
              (upd_sum < 49'(S48_MIN)) ? S48_MIN : upd_sum[47:0];
    wt_sum  = 33'(rd_wt) + 33'(ONE_Q16);
    if (div_neg) q_signed = (div_quo >= 64'h8000_0000_0000) ? S48_MIN : -$signed(div_quo[47:0]);
    else         q_signed = (div_quo > 64'h7FFF_FFFF_FFFF) ? S48_MAX : $signed(div_quo[47:0]);
    acc_sum = 49'(move_acc) + 49'(q_signed);
    acc_sat = (acc_sum > 49'(S48_MAX)) ? S48_MAX :
              (acc_sum < 49'(S48_MIN)) ? S48_MIN : acc_sum[47:0];
    rem_shift = {div_rem[62:0], div_num[63]};
    rem_try   = {1'b0, rem_shift} - {33'd0, div_den};
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = {upd_sat, wt_sum[32] ? 32'hFFFF_FFFF : wt_sum[31:0]};
    rd_addr = idx_q;
    unique case (state)
      ST_CLEAR: begin
        wr_en = 1'b1; wr_addr = ptr; wr_data = '0;
        if (32'(ptr) == DEPTH - 1) state_next = ST_IDLE;
      end
      ST_IDLE: if (in_valid) state_next = (kind_t'(kind) == KIND_DECAY) ? ST_DEC_RD : ST_READ;
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: begin
        unique case (k_q)
          KIND_UPDATE: begin
            wr_en = valid_q;
            state_next = ST_IDLE;
          end
          KIND_MOVE: state_next = (!move_hit && valid_q && rd_wt != 0) ? ST_DIV :
                                  (last_q ? ST_OUT : ST_IDLE);
          KIND_SINGLE: state_next = ST_OUT;
          default: state_next = ST_IDLE;
        endcase
      end
      ST_DIV: if (div_step == 7'd63) state_next = ST_ACC;
      ST_ACC: state_next = last_q ? ST_OUT : ST_IDLE;
      ST_DEC_RD: begin rd_addr = ptr; state_next = ST_DEC_WAIT; end
      ST_DEC_WAIT: state_next = ST_DEC_MUL;
      ST_DEC_MUL: if (mul_phase) state_next = ST_DEC_WR;
      ST_DEC_WR: begin
        wr_en = 1'b1; wr_addr = ptr;
        wr_data = {entry_q[79:32], prod[47:16]};
        state_next = (32'(ptr) == DEPTH - 1) ? ST_IDLE : ST_DEC_RD;
      end
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath registers
  logic [48:0] biased;
  assign biased = 49'(ent_sum) + 49'h0_8000_0000_0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0; move_acc <= '0; move_cnt <= '0; move_hit <= 1'b0;
      out_valid <= 1'b0; mul_phase <= 1'b0;
    end else begin
      unique case (state)
        ST_CLEAR: ptr <= (32'(ptr) == DEPTH - 1) ? '0 : ptr + 1'b1;
        ST_IDLE: if (in_valid) begin
          k_q <= kind_t'(kind); score_q <= score_value; last_q <= last;
          valid_q <= act_ok && (idx_full < (IW+13)'(DEPTH));
          idx_q <= idx_full[AW-1:0];
          ptr <= '0;
        end
        ST_READ: ;
        ST_EXEC: begin
          entry_q <= rd_data;
          if (k_q == KIND_SINGLE) begin
            out_valid <= 1'b1;
            if (!valid_q || rd_wt == 0) begin
              result_sum <= 48'(base_score); result_weight <= ONE_Q16;
              used_default <= 1'b1;
            end else begin
              result_sum <= rd_sum; result_weight <= rd_wt;
              used_default <= 1'b0;
            end
          end else if (k_q == KIND_MOVE) begin
            div_neg  <= rd_data[79];
            div_num  <= {rd_data[79] ? -rd_data[79:32] : rd_data[79:32], 16'd0};
            div_den  <= rd_wt;
            div_rem  <= '0; div_quo <= '0; div_step <= '0;
            if (!move_hit && valid_q && rd_wt != 0) begin
              if (32'(move_cnt) < MAX_MOVE_ACTIONS) move_cnt <= move_cnt + 1'b1;
            end else if (last_q) begin
              // last element not averaged: return the default and clear
              out_valid <= 1'b1;
              result_sum <= 48'(base_score); result_weight <= ONE_Q16;
              used_default <= 1'b1;
              move_acc <= '0; move_cnt <= '0; move_hit <= 1'b0;
            end else begin
              if (32'(move_cnt) < MAX_MOVE_ACTIONS) move_cnt <= move_cnt + 1'b1;
              move_hit <= 1'b1;
            end
          end
        end
        ST_DIV: begin
          // one restoring step a cycle
          div_num <= {div_num[62:0], 1'b0};
          div_step <= div_step + 1'b1;
          if (!rem_try[64]) begin
            div_rem <= rem_try[63:0]; div_quo <= {div_quo[62:0], 1'b1};
          end else begin
            div_rem <= rem_shift; div_quo <= {div_quo[62:0], 1'b0};
          end
        end
        ST_ACC: begin
          // on the last element return the summed averages and clear
          if (last_q) begin
            out_valid <= 1'b1;
            result_sum <= acc_sat;
            result_weight <= {(16-CW)'(0), move_cnt, 16'd0};
            used_default <= 1'b0;
            move_acc <= '0; move_cnt <= '0; move_hit <= 1'b0;
          end else begin
            move_acc <= acc_sat;
          end
        end
        ST_DEC_RD: ;
        ST_DEC_WAIT: begin entry_q <= rd_data; mul_phase <= 1'b0; end
        ST_DEC_MUL: begin
          // sum product first, then weight, through one multiplier
          mul_phase <= ~mul_phase;
          if (!mul_phase) begin
            prod <= 64'(biased[47:0]) * 64'(fade_mult);
          end else begin
            entry_q[79:32] <= 48'(prod[63:16]) - 48'({fade_mult, 31'd0});
            prod <= 64'(ent_wt) * 64'(fade_mult);
          end
        end
        ST_DEC_WR: ptr <= ptr + 1'b1;
        ST_OUT: if (out_ready) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_sum))
    else $error("result dropped");
  a_no_write_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !wr_en) else $error("table written while result waits");
`endif

endmodule
